// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent assertions of the waveform generator.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

// ----- rtl/dds_pkg.sv -----
// ---------------------------------------------------------------------------
// dds_pkg
// Types, constants and the quarter-wave sine table of the waveform generator.
// ---------------------------------------------------------------------------
package dds_pkg;

  // Field widths.
  localparam int FreqW    = 13;
  localparam int AmpW     = 6;
  localparam int ShapeW   = 2;
  localparam int ElapsedW = 16;
  localparam int DacW     = 8;
  localparam int CfgIdxW  = 2;

  // Phase accumulator and table geometry.
  localparam int PhaseBits     = 32;
  localparam int SineTableBits = 10;
  localparam int TableLen      = 1 << SineTableBits;
  localparam int SampleW       = 15;
  localparam int LevelW        = 16;

  // Phase increment = floor(freq * elapsed * 2^PhaseBits / UsPerS) mod 2^PhaseBits.
  // It is formed as a long division in base 2^DigitW: the first digit only
  // reduces the product modulo one million, the next two make up the increment.
  localparam int unsigned UsPerS = 1000000;
  localparam int ProdW     = FreqW + ElapsedW;
  localparam int RemW      = $clog2(UsPerS);
  localparam int DigitW    = PhaseBits / 2;
  localparam int NumW      = RemW + DigitW;
  localparam int DigitCnt  = 3;
  localparam int DigitCntW = $clog2(DigitCnt);

  // UsPerS = 2^UsPow2 * UsOdd, so floor(num / UsPerS) is
  // floor((num >> UsPow2) / UsOdd). The odd divide is an exact reciprocal
  // multiply for every operand below 2^DivXW.
  localparam int UsPow2    = 6;
  localparam int UsOdd     = 15625;
  localparam int DivXW     = NumW - UsPow2;
  localparam int DivShift  = DivXW + $clog2(UsOdd);
  localparam longint unsigned DivRecip =
    ((longint'(1) << DivShift) + longint'(UsOdd) - 1) / longint'(UsOdd);
  localparam int DivRecipW = $clog2(DivRecip + 1);
  localparam int EstW      = DivXW + DivRecipW;
  localparam logic [DivRecipW-1:0] DivRecipMW = DivRecipW'(DivRecip);

  // DAC scaling: code = floor(level * amp * DacFullScale / (66 * 2^15)).
  // 66 * 2^15 = 33 * 2^LevelW, so drop LevelW bits and divide by 33.
  localparam int DacFullScale = 255;
  localparam int DacOddDiv    = 33;
  localparam int ScaleW       = AmpW + $clog2(DacFullScale + 1);
  localparam int ScaledW      = LevelW + ScaleW;
  localparam int XW           = ScaledW - LevelW;
  localparam int RecipShift   = XW + $clog2(DacOddDiv);
  localparam int RecipM       = ((1 << RecipShift) + DacOddDiv - 1) / DacOddDiv;
  localparam int RecipW       = $clog2(RecipM + 1);
  localparam int QuoW         = XW + RecipW - RecipShift;
  localparam logic [RecipW-1:0] RecipMW = RecipW'(RecipM);

  localparam logic [LevelW-1:0] LevelMid = LevelW'(1 << (LevelW - 1));

  // Short queue between front and back.
  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  // Register indexes.
  localparam logic [CfgIdxW-1:0] CfgFrequency = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgAmplitude = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgWaveShape = 2'd2;

  // Reset values.
  localparam logic [FreqW-1:0] FreqReset = 13'd1000;
  localparam logic [AmpW-1:0]  AmpReset  = 6'd33;

  typedef enum logic [ShapeW-1:0] {
    WaveSine,
    WaveSquare,
    WaveTriangle,
    WaveSawtooth
  } wave_shape_e;

  typedef struct packed {
    logic [FreqW-1:0] freq;
    logic [AmpW-1:0]  amp;
    wave_shape_e      shape;
  } cfg_t;

  typedef struct packed {
    logic                 valid;
    logic [PhaseBits-1:0] phase;
  } phase_beat_t;

  typedef logic [SampleW-1:0] sine_rom_t [TableLen];

  // sin(x) for x in Q30 on [0, pi/2], Taylor series to x^13 with truncation.
  function automatic logic [63:0] sine_q30(logic [63:0] x);
    logic [63:0] term;
    logic [63:0] sum;
    term = x;
    sum  = x;
    term = (term * x) >> 30;
    term = ((term * x) >> 30) / 6;
    sum  = sum - term;
    term = (term * x) >> 30;
    term = ((term * x) >> 30) / 20;
    sum  = sum + term;
    term = (term * x) >> 30;
    term = ((term * x) >> 30) / 42;
    sum  = sum - term;
    term = (term * x) >> 30;
    term = ((term * x) >> 30) / 72;
    sum  = sum + term;
    term = (term * x) >> 30;
    term = ((term * x) >> 30) / 110;
    sum  = sum - term;
    term = (term * x) >> 30;
    term = ((term * x) >> 30) / 156;
    sum  = sum + term;
    return sum;
  endfunction

  // Entry k holds round(32767 * sin((k + 1/2) * (pi/2) / TableLen)).
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] x;
    logic [63:0] v;
    for (int k = 0; k < TableLen; k++) begin
      x = (64'd1686629713 * 64'(2 * k + 1)) >> (SineTableBits + 1);
      v = (sine_q30(x) * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      rom[k] = SampleW'(v);
    end
    return rom;
  endfunction

  localparam sine_rom_t SineRom = build_sine_rom();

endpackage

// ----- rtl/dds_front.sv -----
// ---------------------------------------------------------------------------
// dds_front
// Accepts elapsed-time beats and advances the phase accumulator through a
// digit-wise division by one million built on reciprocal multiplies.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dds_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dds_pkg::cfg_t            cfg_i,
  input  logic                     phase_clr_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [dds_pkg::ElapsedW-1:0] in_elapsed_i,
  output dds_pkg::phase_beat_t     push_o,
  input  logic                     push_ready_i
);
  import dds_pkg::*;

  typedef enum logic [2:0] {
    FrIdle,
    FrMul,
    FrEst,
    FrRem,
    FrPush
  } front_state_e;

  front_state_e          state_q;
  logic [ElapsedW-1:0]   elapsed_q;
  logic [NumW-1:0]       num_q;
  logic [DigitW-1:0]     q_q;
  logic [DigitW-1:0]     quot_q;
  logic [DigitCntW-1:0]  dig_q;
  logic [PhaseBits-1:0]  phase_q;

  logic [EstW-1:0]       est;
  logic [NumW-1:0]       rem;

  // Quotient digit by reciprocal multiply, then the partial remainder that
  // feeds the next digit.
  assign est = EstW'(num_q[NumW-1 -: DivXW]) * EstW'(DivRecipMW);
  assign rem = num_q - NumW'(q_q) * NumW'(UsPerS);

  assign in_ready_o   = (state_q == FrIdle);
  assign push_o.valid = (state_q == FrPush);
  assign push_o.phase = phase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FrIdle;
      phase_q <= '0;
      dig_q   <= '0;
    end else begin
      case (state_q)
        FrIdle: begin
          if (phase_clr_i) begin
            phase_q <= '0;
          end
          if (in_valid_i) begin
            elapsed_q <= in_elapsed_i;
            state_q   <= FrMul;
          end
        end
        FrMul: begin
          num_q   <= NumW'(ProdW'(cfg_i.freq) * ProdW'(elapsed_q));
          dig_q   <= '0;
          state_q <= FrEst;
        end
        FrEst: begin
          q_q     <= est[DivShift +: DigitW];
          state_q <= FrRem;
        end
        FrRem: begin
          num_q  <= {rem[RemW-1:0], {DigitW{1'b0}}};
          quot_q <= q_q;
          if (dig_q == DigitCntW'(DigitCnt - 1)) begin
            phase_q <= phase_q + {quot_q, q_q};
            state_q <= FrPush;
          end else begin
            dig_q   <= dig_q + 1'b1;
            state_q <= FrEst;
          end
        end
        FrPush: begin
          if (push_ready_i) begin
            state_q <= FrIdle;
          end
        end
        default: begin
          state_q <= FrIdle;
        end
      endcase
    end
  end

  `ASSERT_PROP(a_rem_bounded, clk_i, rst_ni,
               (state_q == FrRem) |-> (rem < NumW'(UsPerS)),
               "division remainder out of range")
  `ASSERT_PROP(a_push_frees, clk_i, rst_ni,
               (push_o.valid && push_ready_i) |=> in_ready_o,
               "front not ready after handing over a phase")

endmodule

// ----- rtl/dds_queue.sv -----
// ---------------------------------------------------------------------------
// dds_queue
// Short FIFO of phase words between the front and the back.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dds_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dds_pkg::phase_beat_t push_i,
  output logic                 push_ready_o,
  output dds_pkg::phase_beat_t head_o,
  input  logic                 pop_i
);
  import dds_pkg::*;

  logic [PhaseBits-1:0] mem_q [QueueDepth];
  logic [QPtrW-1:0]     wr_ptr_q;
  logic [QPtrW-1:0]     rd_ptr_q;
  logic [QCntW-1:0]     count_q;
  logic                 do_push;
  logic                 do_pop;

  assign push_ready_o = (count_q != QCntW'(QueueDepth));
  assign do_push      = push_i.valid && push_ready_o;
  assign do_pop       = pop_i && head_o.valid;
  assign head_o.valid = (count_q != '0);
  assign head_o.phase = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.phase;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  `ASSERT_PROP(a_pop_nonempty, clk_i, rst_ni, pop_i |-> head_o.valid,
               "pop from an empty phase queue")

endmodule

// ----- rtl/dds_back.sv -----
// ---------------------------------------------------------------------------
// dds_back
// Turns a phase word into a wave level and scales it to a DAC code held in
// an output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dds_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dds_pkg::cfg_t        cfg_i,
  input  dds_pkg::phase_beat_t head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [dds_pkg::DacW-1:0] out_code_o
);
  import dds_pkg::*;

  typedef enum logic [2:0] {
    BkIdle,
    BkMix,
    BkScale,
    BkDiv,
    BkDone
  } back_state_e;

  back_state_e              state_q;
  logic [PhaseBits-1:0]     phase_q;
  logic [1:0]               quad_q;
  logic [SampleW-1:0]       rom_q;
  logic [LevelW-1:0]        level_q;
  logic [ScaledW-1:0]       scaled_q;
  logic [XW+RecipW-1:0]     recip_q;
  logic                     out_valid_q;
  logic [DacW-1:0]          out_code_q;

  logic [SineTableBits-1:0] rom_idx;
  logic [1:0]               head_quad;
  logic [LevelW:0]          tri_u;
  logic [LevelW-1:0]        level_d;
  logic [ScaleW-1:0]        amp_scale;
  logic [QuoW-1:0]          quo;
  logic [DacW-1:0]          code_d;
  logic                     out_free;
  logic                     out_load;

  // Quadrants 1 and 3 read the quarter table mirrored.
  assign head_quad = head_i.phase[PhaseBits-1 -: 2];
  assign rom_idx   = head_quad[0] ? ~head_i.phase[PhaseBits-3 -: SineTableBits]
                                  : head_i.phase[PhaseBits-3 -: SineTableBits];

  assign tri_u = phase_q[PhaseBits-1 -: LevelW+1];

  // Wave level, already offset to 0..65535.
  always_comb begin
    case (cfg_i.shape)
      WaveSine: begin
        level_d = quad_q[1] ? LevelMid - LevelW'(rom_q) : LevelMid + LevelW'(rom_q);
      end
      WaveSquare: begin
        level_d = phase_q[PhaseBits-1] ? '0 : '1;
      end
      WaveTriangle: begin
        if (!tri_u[LevelW]) begin
          level_d = tri_u[LevelW-1:0];
        end else if (tri_u[LevelW-1:0] == '0) begin
          level_d = '1;
        end else begin
          level_d = ~tri_u[LevelW-1:0] + 1'b1;
        end
      end
      default: begin
        level_d = phase_q[PhaseBits-1 -: LevelW];
      end
    endcase
  end

  assign amp_scale = ScaleW'(cfg_i.amp) * ScaleW'(DacFullScale);
  assign quo       = recip_q[XW+RecipW-1:RecipShift];
  assign code_d    = (quo > QuoW'(DacFullScale)) ? DacW'(DacFullScale) : DacW'(quo);
  assign out_free  = !out_valid_q || out_ready_i;
  assign out_load  = (state_q == BkDone) && out_free;

  assign pop_o       = (state_q == BkIdle) && head_i.valid;
  assign out_valid_o = out_valid_q;
  assign out_code_o  = out_code_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkIdle;
      out_valid_q <= 1'b0;
    end else begin
      // A new code replaces the one that leaves in the same cycle.
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        BkIdle: begin
          if (head_i.valid) begin
            phase_q <= head_i.phase;
            quad_q  <= head_quad;
            rom_q   <= SineRom[rom_idx];
            state_q <= BkMix;
          end
        end
        BkMix: begin
          level_q <= level_d;
          state_q <= BkScale;
        end
        BkScale: begin
          scaled_q <= ScaledW'(level_q) * ScaledW'(amp_scale);
          state_q  <= BkDiv;
        end
        BkDiv: begin
          recip_q <= (XW + RecipW)'(scaled_q[ScaledW-1:LevelW]) * (XW + RecipW)'(RecipMW);
          state_q <= BkDone;
        end
        BkDone: begin
          if (out_load) begin
            out_code_q <= code_d;
            state_q    <= BkIdle;
          end
        end
        default: begin
          state_q <= BkIdle;
        end
      endcase
    end
  end

  `ASSERT_PROP(a_hold_when_blocked, clk_i, rst_ni,
               (state_q == BkDone && out_valid_q && !out_ready_i) |=> (state_q == BkDone),
               "result overwritten while the output register was full")
  `ASSERT_PROP(a_load_from_done, clk_i, rst_ni,
               $rose(out_valid_q) |-> ($past(state_q) == BkDone),
               "output register loaded outside the final step")

endmodule

// ----- rtl/dds_waveform_generator.sv -----
// ---------------------------------------------------------------------------
// dds_waveform_generator
// Direct digital synthesis function generator: sine, square, triangle and
// sawtooth waves mapped to an 8-bit DAC code, one code per sample tick.
// ---------------------------------------------------------------------------
//
// Channel    Direction  Beat contents
// s_axis_*   in         elapsed microseconds since the previous tick
// m_axis_*   out        DAC code for that tick
// cfg_*      in         register write: index and data
//
// The front accepts a tick beat, forms the frequency-times-time product,
// divides it by one million (three base-65536 quotient digits, each a
// reciprocal multiply followed by a remainder step) and hands the phase
// over, waiting while the queue is full; it takes no new beat until then. The
// back steps through table lookup, level, scaling, the divide by 33 and the
// output load, fewer steps than the front, so the front sets the rate while
// the consumer keeps up. A two-entry phase queue and the output register let
// a stalled consumer hold results without stopping the front until the queue
// fills. Reset clears the phase and loads the register defaults (1000 Hz,
// 3.3 V, sine); there is no start-up pass.
// ---------------------------------------------------------------------------
module dds_waveform_generator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Sample ticks. tdata: [15:0] elapsed_us.
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [dds_pkg::ElapsedW-1:0]      s_axis_tdata_i,
  // DAC codes. tdata: [7:0] dac_code.
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [dds_pkg::DacW-1:0]          m_axis_tdata_o,
  // Register writes.
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [dds_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [dds_pkg::FreqW-1:0]         cfg_data_i
);
  import dds_pkg::*;

  logic [FreqW-1:0] freq_q;
  logic [AmpW-1:0]  amp_q;
  wave_shape_e      shape_q;
  cfg_t             cfg;
  logic             cfg_write;
  logic             phase_clr;

  phase_beat_t      push_beat;
  logic             push_ready;
  phase_beat_t      head_beat;
  logic             pop;

  // Register writes are always taken; the user must issue them only while idle, as the block does not enforce it.
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;
  // A write of the wave shape restarts the waveform at phase zero if the front is idle.
  assign phase_clr   = cfg_write && (cfg_index_i == CfgWaveShape);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q  <= FreqReset;
      amp_q   <= AmpReset;
      shape_q <= WaveSine;
    end else if (cfg_write) begin
      case (cfg_index_i)
        CfgFrequency: freq_q  <= cfg_data_i;
        CfgAmplitude: amp_q   <= cfg_data_i[AmpW-1:0];
        CfgWaveShape: shape_q <= wave_shape_e'(cfg_data_i[ShapeW-1:0]);
        default: begin
          // Writes to indexes outside the register list are dropped.
        end
      endcase
    end
  end

  assign cfg.freq  = freq_q;
  assign cfg.amp   = amp_q;
  assign cfg.shape = shape_q;

  // Front: tick acceptance, phase increment and accumulation.
  dds_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .phase_clr_i  (phase_clr),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_elapsed_i (s_axis_tdata_i),
    .push_o       (push_beat),
    .push_ready_i (push_ready)
  );

  // Decouples the phase producer from the waveform back end.
  dds_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_beat),
    .push_ready_o (push_ready),
    .head_o       (head_beat),
    .pop_i        (pop)
  );

  // Back: wave lookup, amplitude scaling and the output register.
  dds_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .head_i      (head_beat),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_code_o  (m_axis_tdata_o)
  );

endmodule

// ----- bench/dds_waveform_generator_tb.sv -----
// ---------------------------------------------------------------------------
// dds_waveform_generator_tb
// Self-checking bench for the DDS waveform generator. Tick beats with random
// elapsed times go in on the slave stream, and DAC codes come back on the
// master stream. A local phase accumulator, a locally built quarter-wave sine
// table and the DAC scaling give the expected code for every tick. Register
// writes happen only while the generator is drained, and the random phases
// sweep frequency, amplitude and wave shape, extremes included.
// ---------------------------------------------------------------------------
module dds_waveform_generator_tb;
  import dds_pkg::*;

  // Index 3 is not a register; a write there must leave everything alone.
  localparam logic [CfgIdxW-1:0] CfgNoReg = 2'd3;
  localparam int unsigned MicrosPerSec = 1000000;
  localparam int ItemTarget = 850;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [ElapsedW-1:0] s_axis_tdata_i = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [DacW-1:0]     m_axis_tdata_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [FreqW-1:0]    cfg_data_i = '0;

  dds_waveform_generator u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Generous ceiling, well above the slowest correct run.
  initial begin
    #8000000;
    $display("dds_waveform_generator_tb: done, errors");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Shadow state of the generator: registers, phase and the sine table.
  // -------------------------------------------------------------------------
  logic [FreqW-1:0]     shadow_freq  = FreqReset;
  logic [AmpW-1:0]      shadow_amp   = AmpReset;
  wave_shape_e          shadow_shape = WaveSine;
  logic [PhaseBits-1:0] shadow_phase = '0;
  int                   quarter_sine [TableLen];

  logic [ElapsedW-1:0]  pending_ticks [$];
  logic [DacW-1:0]      expected_codes [$];
  bit                   tick_taken = 1'b0;
  int                   send_idle_pct = 0;
  int                   recv_idle_pct = 0;
  int                   ticks_issued = 0;
  int                   mismatches = 0;

  // Q30 sine on [0, pi/2] from the Taylor series up to x^13, every product
  // truncated back to Q30.
  function automatic logic [63:0] sin_q30(logic [63:0] x);
    logic [63:0] term;
    logic [63:0] sum;
    term = x;
    sum  = x;
    for (int i = 1; i <= 6; i++) begin
      term = (term * x) >> 30;
      term = ((term * x) >> 30) / 64'((2 * i) * (2 * i + 1));
      if (i % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  // Phase advance for one tick: floor(f * t * 2^32 / 1e6) mod 2^32. Whole
  // turns are dropped first, so only the remainder of f * t matters.
  function automatic logic [PhaseBits-1:0] phase_advance(logic [FreqW-1:0] freq,
                                                         logic [ElapsedW-1:0] elapsed);
    logic [63:0] rem;
    rem = (64'(freq) * 64'(elapsed)) % 64'(MicrosPerSec);
    return PhaseBits'((rem << PhaseBits) / 64'(MicrosPerSec));
  endfunction

  // Offset-binary sample level 0..65535, i.e. the Q1.15 value plus 32768.
  function automatic int wave_level(wave_shape_e shape, logic [PhaseBits-1:0] ph);
    logic [1:0] quadrant;
    int         idx;
    int         upos;
    int         lvl;
    case (shape)
      WaveSine: begin
        quadrant = ph[PhaseBits-1 -: 2];
        idx = int'(ph[PhaseBits-3 -: SineTableBits]);
        if (quadrant[0]) begin
          idx = TableLen - 1 - idx;
        end
        lvl = quadrant[1] ? 32768 - quarter_sine[idx] : 32768 + quarter_sine[idx];
      end
      WaveSquare: begin
        lvl = ph[PhaseBits-1] ? 0 : 65535;
      end
      WaveTriangle: begin
        // Rising over the first half turn, falling over the second; the peak
        // at exactly half a turn saturates to full scale.
        upos = int'(ph[PhaseBits-1 -: 17]);
        lvl  = (upos < 65536) ? upos : 131072 - upos;
        if (lvl > 65535) begin
          lvl = 65535;
        end
      end
      default: begin
        lvl = int'(ph[PhaseBits-1 -: 16]);
      end
    endcase
    return lvl;
  endfunction

  function automatic logic [DacW-1:0] dac_from_level(int lvl, logic [AmpW-1:0] amp);
    longint code;
    code = (longint'(lvl) * longint'(amp) * DacFullScale) / (66 * 32768);
    if (code > DacFullScale) begin
      code = DacFullScale;
    end
    return DacW'(code);
  endfunction

  // -------------------------------------------------------------------------
  // Tick driver. A beat stays up until it is taken; a new one may be held
  // back to open a gap in the stream.
  // -------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else if (!s_axis_tvalid_i || tick_taken) begin
      if (pending_ticks.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= pending_ticks.pop_front();
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
    tick_taken = 1'b0;
  end

  // Back-pressure on the DAC stream.
  always @(negedge clk_i) begin
    m_axis_tready_i <= rst_ni && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Every accepted tick advances the shadow phase and queues its code.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      shadow_phase = shadow_phase + phase_advance(shadow_freq, s_axis_tdata_i);
      expected_codes.push_back(dac_from_level(wave_level(shadow_shape, shadow_phase),
                                              shadow_amp));
      tick_taken = 1'b1;
    end
  end

  // DAC code checker: each beat against the oldest pending code.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_codes.size() == 0) begin
        $error("dac_code: unexpected beat %0d with no tick pending", m_axis_tdata_o);
        mismatches++;
      end else if (m_axis_tdata_o !== expected_codes[0]) begin
        $error("dac_code: expected %0d, actual %0d", expected_codes[0], m_axis_tdata_o);
        mismatches++;
        void'(expected_codes.pop_front());
      end else begin
        void'(expected_codes.pop_front());
      end
    end
  end

  // -------------------------------------------------------------------------
  // Register writes and sequencing.
  // -------------------------------------------------------------------------
  task automatic write_register(input logic [CfgIdxW-1:0] idx,
                                input logic [FreqW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do begin
      @(posedge clk_i);
    end while (!cfg_ready_o);
    case (idx)
      CfgFrequency: shadow_freq = data;
      CfgAmplitude: shadow_amp = data[AmpW-1:0];
      CfgWaveShape: begin
        shadow_shape = wave_shape_e'(data[ShapeW-1:0]);
        shadow_phase = '0;
      end
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Waits until every tick has been taken and every code has come back.
  // Each tick yields exactly one code, so the block is idle after that.
  task automatic drain();
    while (pending_ticks.size() != 0 || s_axis_tvalid_i || expected_codes.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic queue_ticks(input logic [ElapsedW-1:0] elapsed);
    pending_ticks.push_back(elapsed);
    ticks_issued++;
  endtask

  // Idling follows the run: sender-light first, receiver-light next, none
  // at the end.
  task automatic pick_idling();
    if (ticks_issued >= 2 * ItemTarget / 3) begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end else if (ticks_issued < ItemTarget / 3) begin
      send_idle_pct = 22;
      recv_idle_pct = 78;
    end else begin
      send_idle_pct = 78;
      recv_idle_pct = 22;
    end
  endtask

  function automatic logic [ElapsedW-1:0] random_elapsed();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return ElapsedW'($urandom_range(0, 400));
      4:       return ElapsedW'(250 * $urandom_range(0, 4));
      default: return ElapsedW'($urandom);
    endcase
  endfunction

  task automatic random_settings();
    logic [FreqW-1:0] freq;
    logic [AmpW-1:0]  amp;
    if ($urandom_range(0, 9) < 6) begin
      case ($urandom_range(0, 9))
        0:       freq = '0;
        1:       freq = '1;
        2:       freq = 13'd1;
        3:       freq = 13'd4999;
        4:       freq = FreqW'($urandom);
        default: freq = FreqW'($urandom_range(1, 4999));
      endcase
      write_register(CfgFrequency, freq);
    end
    if ($urandom_range(0, 9) < 6) begin
      case ($urandom_range(0, 7))
        0:       amp = '0;
        1:       amp = '1;
        2:       amp = AmpReset;
        3:       amp = AmpW'($urandom_range(34, 63));
        default: amp = AmpW'($urandom_range(0, 33));
      endcase
      // Bits above the amplitude field must be ignored.
      write_register(CfgAmplitude, {FreqW'($urandom) >> AmpW << AmpW} | FreqW'(amp));
    end
    if ($urandom_range(0, 9) < 7) begin
      write_register(CfgWaveShape, FreqW'($urandom) & ~FreqW'(3) | FreqW'($urandom_range(0, 3)));
    end
  endtask

  initial begin
    int burst;

    for (int k = 0; k < TableLen; k++) begin
      quarter_sine[k] = int'(((sin_q30((64'd1686629713 * 64'(2 * k + 1)) >> (SineTableBits + 1))
                                * 64'd32767) + (64'd1 << 29)) >> 30);
      if (quarter_sine[k] > 32767) begin
        quarter_sine[k] = 32767;
      end
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    pick_idling();

    // Reset settings, 1000 Hz: 250 us is exactly a quarter turn, so the sine
    // walks through every quadrant boundary, then the field extremes.
    queue_ticks(16'd0);
    repeat (4) queue_ticks(16'd250);
    queue_ticks(16'd1);
    queue_ticks(16'hFFFF);
    queue_ticks(16'hAAAA);
    queue_ticks(16'h5555);
    drain();

    // Triangle: a 500 us tick lands exactly on half a turn, the saturating peak.
    write_register(CfgWaveShape, FreqW'(WaveTriangle));
    queue_ticks(16'd500);
    queue_ticks(16'd250);
    queue_ticks(16'd250);
    drain();

    // Zero frequency holds the phase; amplitude above full scale clamps.
    write_register(CfgFrequency, '0);
    write_register(CfgAmplitude, '1);
    write_register(CfgWaveShape, FreqW'(WaveSquare));
    queue_ticks(16'hFFFF);
    queue_ticks(16'd777);
    drain();

    // Highest frequency with the longest tick drops many whole turns; zero
    // amplitude gives a flat zero code.
    write_register(CfgFrequency, '1);
    write_register(CfgAmplitude, '0);
    write_register(CfgWaveShape, FreqW'(WaveSawtooth));
    queue_ticks(16'hFFFF);
    queue_ticks(16'd40000);
    drain();

    write_register(CfgAmplitude, AmpReset);
    write_register(CfgFrequency, 13'd4999);
    queue_ticks(16'hFFFF);
    queue_ticks(16'd100);
    queue_ticks(16'd3);
    drain();

    // A write to the unused index changes nothing, the phase included.
    write_register(CfgNoReg, '1);
    queue_ticks(16'd100);
    drain();

    // Square edge at exactly half a turn.
    write_register(CfgFrequency, FreqReset);
    write_register(CfgWaveShape, FreqW'(WaveSquare));
    queue_ticks(16'd500);
    queue_ticks(16'd500);
    drain();

    // Random phases: new settings, then a run of ticks.
    while (ticks_issued < ItemTarget) begin
      random_settings();
      pick_idling();
      burst = $urandom_range(15, 50);
      repeat (burst) queue_ticks(random_elapsed());
      drain();
    end

    repeat (16) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("dds_waveform_generator_tb: done, clean");
    end else begin
      $display("dds_waveform_generator_tb: done, errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/dds_pkg.sv
rtl/dds_front.sv
rtl/dds_queue.sv
rtl/dds_back.sv
rtl/dds_waveform_generator.sv
bench/dds_waveform_generator_tb.sv
